[sv/grapheme_cluster_segmenter_macros.svh]
// Assertion macros for the checks in the top-level segmenter file.
`ifndef GRAPHEME_CLUSTER_SEGMENTER_MACROS_SVH
`define GRAPHEME_CLUSTER_SEGMENTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GCS_ASSERT_IMP(name, clk_sig, rst_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("grapheme_cluster_segmenter: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define GCS_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("grapheme_cluster_segmenter: next-cycle check failed");

`endif

[sv/gcs_pkg.sv]
package gcs_pkg;

    // Default trie geometry.
    localparam int TRIE_BLOCK_SIZE = 256;
    localparam int INDEX_DEPTH     = 4352;
    localparam int BLOCK_COUNT     = 256;

    // Table addresses are 16 bits wide, so no table holds more entries.
    localparam int TABLE_SPAN = 65536;

    // Depth of the queue between front and back, and of the result queue.
    localparam int QUEUE_DEPTH  = 4;
    localparam int RESULT_DEPTH = 2;

    // Operation codes of an input transaction.
    localparam logic [1:0] FUNC_DATA     = 2'd0;
    localparam logic [1:0] FUNC_INDEX_WR = 2'd1;
    localparam logic [1:0] FUNC_KIND_WR  = 2'd2;

    // Break kinds.
    localparam logic [3:0] KIND_NONE     = 4'd0;
    localparam logic [3:0] KIND_CR       = 4'd1;
    localparam logic [3:0] KIND_LF       = 4'd2;
    localparam logic [3:0] KIND_CONTROL  = 4'd3;
    localparam logic [3:0] KIND_EXTEND   = 4'd4;
    localparam logic [3:0] KIND_ZWJ      = 4'd5;
    localparam logic [3:0] KIND_SPACING  = 4'd6;
    localparam logic [3:0] KIND_PREPEND  = 4'd7;
    localparam logic [3:0] KIND_L        = 4'd8;
    localparam logic [3:0] KIND_V        = 4'd9;
    localparam logic [3:0] KIND_T        = 4'd10;
    localparam logic [3:0] KIND_LV       = 4'd11;
    localparam logic [3:0] KIND_LVT      = 4'd12;
    localparam logic [3:0] KIND_EXT_PICT = 4'd13;

    // Rule operand that matches any kind.
    localparam logic [4:0] RULE_WILD = 5'd16;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [20:0] MAX_CP         = 21'h10FFFF;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  data_byte;
        logic        is_last;
        logic [15:0] table_address;
        logic [7:0]  table_value;
    } in_item_t;

    typedef struct packed {
        logic [15:0] cluster_bytes;
        logic        width_saturated;
        logic        ends_text;
        logic        last_of_run;
    } result_t;

    // A classified codepoint (or end marker) handed from front to back.
    typedef struct packed {
        logic [3:0] kind;
        logic [2:0] width;
        logic       done;
        logic       last;
    } class_item_t;

    typedef struct packed {
        logic [4:0] lhs;
        logic [4:0] rhs;
        logic       joins_pair;
    } pair_rule_t;

    localparam int RULE_COUNT = 23;

    // Ordered pairwise rules; the first match decides.
    localparam pair_rule_t PAIR_RULES [RULE_COUNT] = '{
        '{5'(KIND_CR),      5'(KIND_LF),       1'b1},
        '{5'(KIND_CONTROL), RULE_WILD,         1'b0},
        '{5'(KIND_CR),      RULE_WILD,         1'b0},
        '{5'(KIND_LF),      RULE_WILD,         1'b0},
        '{RULE_WILD,        5'(KIND_CONTROL),  1'b0},
        '{RULE_WILD,        5'(KIND_CR),       1'b0},
        '{RULE_WILD,        5'(KIND_LF),       1'b0},
        '{5'(KIND_L),       5'(KIND_L),        1'b1},
        '{5'(KIND_L),       5'(KIND_V),        1'b1},
        '{5'(KIND_L),       5'(KIND_LV),       1'b1},
        '{5'(KIND_L),       5'(KIND_LVT),      1'b1},
        '{5'(KIND_LV),      5'(KIND_V),        1'b1},
        '{5'(KIND_LV),      5'(KIND_T),        1'b1},
        '{5'(KIND_V),       5'(KIND_V),        1'b1},
        '{5'(KIND_V),       5'(KIND_T),        1'b1},
        '{5'(KIND_LVT),     5'(KIND_T),        1'b1},
        '{5'(KIND_T),       5'(KIND_T),        1'b1},
        '{RULE_WILD,        5'(KIND_EXTEND),   1'b1},
        '{RULE_WILD,        5'(KIND_ZWJ),      1'b1},
        '{RULE_WILD,        5'(KIND_SPACING),  1'b1},
        '{5'(KIND_PREPEND), RULE_WILD,         1'b1},
        '{5'(KIND_EXTEND),  5'(KIND_ZWJ),      1'b1},
        '{5'(KIND_ZWJ),     5'(KIND_EXT_PICT), 1'b1}
    };

    // True when the pair (a, b) joins; a None on either side always breaks.
    function automatic logic pair_joins(input logic [3:0] a, input logic [3:0] b);
        logic       found;
        logic       result;
        logic [4:0] a5;
        logic [4:0] b5;
        found  = 1'b0;
        result = 1'b0;
        a5     = {1'b0, a};
        b5     = {1'b0, b};
        if (a == KIND_NONE || b == KIND_NONE)
        begin
            found = 1'b1;
        end
        for (int i = 0; i < RULE_COUNT; i++)
        begin
            if (!found &&
                ((PAIR_RULES[i].lhs == a5 && PAIR_RULES[i].rhs == RULE_WILD) ||
                 (PAIR_RULES[i].lhs == RULE_WILD && PAIR_RULES[i].rhs == b5) ||
                 (PAIR_RULES[i].lhs == a5 && PAIR_RULES[i].rhs == b5)))
            begin
                found  = 1'b1;
                result = PAIR_RULES[i].joins_pair;
            end
        end
        return result;
    endfunction

endpackage

[sv/gcs_ram.sv]
module gcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/gcs_fifo.sv]
module gcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[sv/gcs_front.sv]
module gcs_front #(
    parameter int TRIE_BLOCK_SIZE = gcs_pkg::TRIE_BLOCK_SIZE,
    parameter int INDEX_DEPTH     = gcs_pkg::INDEX_DEPTH,
    parameter int BLOCK_COUNT     = gcs_pkg::BLOCK_COUNT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  gcs_pkg::in_item_t    item,
    output logic                 full,
    input  logic                 slot_free,
    output logic                 out_valid,
    output gcs_pkg::class_item_t out_data
);

    // The block size is a power of two, so the trie split is a bit split.
    localparam int BLOCK_BITS     = $clog2(TRIE_BLOCK_SIZE);
    localparam int KIND_DEPTH     = BLOCK_COUNT * TRIE_BLOCK_SIZE;
    localparam int IDX_RAM_DEPTH  = (INDEX_DEPTH < gcs_pkg::TABLE_SPAN) ?
                                    INDEX_DEPTH : gcs_pkg::TABLE_SPAN;
    localparam int KIND_RAM_DEPTH = (KIND_DEPTH < gcs_pkg::TABLE_SPAN) ?
                                    KIND_DEPTH : gcs_pkg::TABLE_SPAN;
    localparam int IDX_AW         = $clog2(IDX_RAM_DEPTH);
    localparam int KIND_AW        = $clog2(KIND_RAM_DEPTH);
    localparam int CW             = $clog2(gcs_pkg::QUEUE_DEPTH + 1);

    // UTF-8 decoder state.
    logic [20:0] acc_reg;
    logic [20:0] acc_next;
    logic [1:0]  rem_reg;
    logic [1:0]  rem_next;
    logic [2:0]  len_reg;
    logic [2:0]  len_next;

    // Slots reserved in the middle queue, counting items still in flight.
    logic [CW-1:0] credit_reg;
    logic [CW-1:0] credit_next;

    logic        accept;
    logic        is_data;
    logic        is_cont;
    logic        dec_done;
    logic [20:0] dec_cp;
    logic [2:0]  dec_width;
    logic        needs_back;
    logic [20:0] cp_lookup;
    logic [20:0] hi_word;
    logic        hi_ok;

    // Index lookup stage.
    logic                  s1_valid_reg;
    logic                  s1_done_reg;
    logic                  s1_last_reg;
    logic [2:0]            s1_width_reg;
    logic [BLOCK_BITS-1:0] s1_lo_reg;
    logic                  s1_hi_ok_reg;

    // Kind lookup stage.
    logic       s2_valid_reg;
    logic       s2_done_reg;
    logic       s2_last_reg;
    logic [2:0] s2_width_reg;
    logic       s2_none_reg;

    logic              idx_we;
    logic [7:0]        idx_rdata;
    logic              kind_we;
    logic [3:0]        kind_rdata;
    logic [31:0]       kind_addr_full;
    logic              blk_ok;

    assign full    = (credit_reg == CW'(gcs_pkg::QUEUE_DEPTH));
    assign accept  = push && !full;
    assign is_data = accept && (item.func == gcs_pkg::FUNC_DATA);
    assign is_cont = (item.data_byte[7:6] == 2'b10);

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        len_next  = len_reg;
        dec_done  = 1'b0;
        dec_cp    = '0;
        dec_width = '0;
        if (rem_reg != 2'd0)
        begin
            if (is_cont)
            begin
                acc_next = {acc_reg[14:0], item.data_byte[5:0]};
                len_next = len_reg + 3'd1;
                rem_next = rem_reg - 2'd1;
                if (rem_reg == 2'd1)
                begin
                    dec_done  = 1'b1;
                    dec_cp    = acc_next;
                    dec_width = len_next;
                end
            end
            else
            begin
                // A sequence cut short counts, with the breaking byte, as one U+FFFD.
                dec_done  = 1'b1;
                dec_cp    = gcs_pkg::REPLACEMENT_CP;
                dec_width = len_reg + 3'd1;
                rem_next  = 2'd0;
            end
        end
        else if (!item.data_byte[7])
        begin
            dec_done  = 1'b1;
            dec_cp    = {13'd0, item.data_byte};
            dec_width = 3'd1;
        end
        else if (item.data_byte inside {[8'h80:8'hBF], [8'hF8:8'hFF]})
        begin
            dec_done  = 1'b1;
            dec_cp    = gcs_pkg::REPLACEMENT_CP;
            dec_width = 3'd1;
        end
        else
        begin
            len_next = 3'd1;
            if (item.data_byte < 8'hE0)
            begin
                acc_next = {16'd0, item.data_byte[4:0]};
                rem_next = 2'd1;
            end
            else if (item.data_byte < 8'hF0)
            begin
                acc_next = {17'd0, item.data_byte[3:0]};
                rem_next = 2'd2;
            end
            else
            begin
                acc_next = {18'd0, item.data_byte[2:0]};
                rem_next = 2'd3;
            end
        end
        // The text ends inside a sequence: the pending bytes form one U+FFFD.
        if (!dec_done && item.is_last && rem_next != 2'd0)
        begin
            dec_done  = 1'b1;
            dec_cp    = gcs_pkg::REPLACEMENT_CP;
            dec_width = len_next;
            rem_next  = 2'd0;
        end
        if (dec_done)
        begin
            acc_next = '0;
            len_next = '0;
        end
        if (item.is_last)
        begin
            acc_next = '0;
            len_next = '0;
            rem_next = '0;
        end
    end

    assign needs_back = is_data && (dec_done || item.is_last);
    assign cp_lookup  = (dec_cp > gcs_pkg::MAX_CP) ? gcs_pkg::REPLACEMENT_CP : dec_cp;
    assign hi_word    = cp_lookup >> BLOCK_BITS;
    assign hi_ok      = (32'(hi_word) < 32'(INDEX_DEPTH));

    assign idx_we  = accept && (item.func == gcs_pkg::FUNC_INDEX_WR) &&
                     ({16'd0, item.table_address} < 32'(INDEX_DEPTH));
    assign kind_we = accept && (item.func == gcs_pkg::FUNC_KIND_WR) &&
                     ({16'd0, item.table_address} < 32'(KIND_DEPTH));

    gcs_ram #(
        .WIDTH (8),
        .DEPTH (IDX_RAM_DEPTH)
    ) u_index_ram (
        .clk   (clk),
        .we    (idx_we),
        .waddr (item.table_address[IDX_AW-1:0]),
        .wdata (item.table_value),
        .raddr (hi_word[IDX_AW-1:0]),
        .rdata (idx_rdata)
    );

    assign blk_ok         = (32'(idx_rdata) < 32'(BLOCK_COUNT));
    assign kind_addr_full = (32'(idx_rdata) << BLOCK_BITS) | 32'(s1_lo_reg);

    gcs_ram #(
        .WIDTH (4),
        .DEPTH (KIND_RAM_DEPTH)
    ) u_kind_ram (
        .clk   (clk),
        .we    (kind_we),
        .waddr (item.table_address[KIND_AW-1:0]),
        .wdata (item.table_value[3:0]),
        .raddr (kind_addr_full[KIND_AW-1:0]),
        .rdata (kind_rdata)
    );

    always_comb
    begin
        credit_next = credit_reg;
        if (needs_back && !slot_free)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (slot_free && !needs_back)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            rem_reg      <= '0;
            len_reg      <= '0;
            credit_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (is_data)
            begin
                acc_reg <= acc_next;
                rem_reg <= rem_next;
                len_reg <= len_next;
            end
            credit_reg   <= credit_next;
            s1_valid_reg <= needs_back;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_done_reg  <= dec_done;
        s1_last_reg  <= item.is_last;
        s1_width_reg <= dec_width;
        s1_lo_reg    <= cp_lookup[BLOCK_BITS-1:0];
        s1_hi_ok_reg <= hi_ok;
        s2_done_reg  <= s1_done_reg;
        s2_last_reg  <= s1_last_reg;
        s2_width_reg <= s1_width_reg;
        s2_none_reg  <= !s1_hi_ok_reg || !blk_ok;
    end

    assign out_valid      = s2_valid_reg;
    assign out_data.kind  = s2_none_reg ? gcs_pkg::KIND_NONE : kind_rdata;
    assign out_data.width = s2_width_reg;
    assign out_data.done  = s2_done_reg;
    assign out_data.last  = s2_last_reg;

endmodule

[sv/gcs_back.sv]
module gcs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  gcs_pkg::class_item_t head,
    output logic                 head_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output gcs_pkg::result_t     res_data
);

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [3:0]  prev_kind_reg;
    logic        have_prev_reg;
    logic [15:0] count_reg;
    logic        clamp_reg;

    logic             join_ok;
    logic             brk;
    logic             two_results;
    logic             no_result;
    logic [15:0]      base_count;
    logic             base_clamp;
    logic [16:0]      sum;
    logic [15:0]      grown_count;
    logic             grown_clamp;
    gcs_pkg::result_t res_a;
    gcs_pkg::result_t res_b;

    assign join_ok     = have_prev_reg && gcs_pkg::pair_joins(prev_kind_reg, head.kind);
    assign brk         = head.done && !join_ok && have_prev_reg;
    assign two_results = brk && head.last;
    assign no_result   = !brk && !head.last;

    assign base_count  = join_ok ? count_reg : 16'd0;
    assign base_clamp  = join_ok && clamp_reg;
    assign sum         = {1'b0, base_count} + 17'(head.width);
    assign grown_count = sum[16] ? 16'hFFFF : sum[15:0];
    assign grown_clamp = base_clamp || sum[16];

    // The cluster closed by a break, and the cluster closed by the end of text.
    assign res_a = '{cluster_bytes: count_reg, width_saturated: clamp_reg,
                     ends_text: 1'b0, last_of_run: !head.last};
    assign res_b = '{cluster_bytes: head.done ? grown_count : count_reg,
                     width_saturated: head.done ? grown_clamp : clamp_reg,
                     ends_text: 1'b1, last_of_run: 1'b1};

    always_comb
    begin
        res_push   = 1'b0;
        head_pop   = 1'b0;
        res_data   = res_b;
        phase_next = phase_reg;
        if (head_valid)
        begin
            case (phase_reg)
                PH_FIRST:
                begin
                    if (no_result)
                    begin
                        head_pop = 1'b1;
                    end
                    else if (!res_full)
                    begin
                        res_push = 1'b1;
                        res_data = brk ? res_a : res_b;
                        if (two_results)
                        begin
                            phase_next = PH_SECOND;
                        end
                        else
                        begin
                            head_pop = 1'b1;
                        end
                    end
                end
                PH_SECOND:
                begin
                    if (!res_full)
                    begin
                        res_push   = 1'b1;
                        head_pop   = 1'b1;
                        phase_next = PH_FIRST;
                    end
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            prev_kind_reg <= gcs_pkg::KIND_NONE;
            have_prev_reg <= 1'b0;
            count_reg     <= '0;
            clamp_reg     <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (head_pop)
            begin
                if (head.last)
                begin
                    prev_kind_reg <= gcs_pkg::KIND_NONE;
                    have_prev_reg <= 1'b0;
                    count_reg     <= '0;
                    clamp_reg     <= 1'b0;
                end
                else if (head.done)
                begin
                    prev_kind_reg <= head.kind;
                    have_prev_reg <= 1'b1;
                    count_reg     <= grown_count;
                    clamp_reg     <= grown_clamp;
                end
            end
        end
    end

endmodule

[sv/grapheme_cluster_segmenter.sv]
// Throughput: one input transaction per cycle while full is low; a byte that both ends a
// cluster and ends the text yields two results, which the back end writes one at a time.
// Path of a result: index lookup, kind lookup, middle queue, then the rule check writes
// it into the result queue, which drives the result ports.
// Reset (rst_n, asynchronous, active low) clears decoder, cluster and queue state;
// the trie tables are not cleared and must be written before any text is sent.
`include "grapheme_cluster_segmenter_macros.svh"

module grapheme_cluster_segmenter #(
    parameter int TRIE_BLOCK_SIZE = gcs_pkg::TRIE_BLOCK_SIZE,
    parameter int INDEX_DEPTH     = gcs_pkg::INDEX_DEPTH,
    parameter int BLOCK_COUNT     = gcs_pkg::BLOCK_COUNT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  gcs_pkg::in_item_t item,
    output logic              empty,
    input  logic              pop,
    output gcs_pkg::result_t  result
);

    // The front end decodes UTF-8, runs the two trie lookups and handles the
    // table write transactions. Writes hit the tables as they are accepted, and
    // a read of an entry being written returns its old contents, so every
    // lookup sees exactly the writes that came before it. Only transactions
    // that finish a codepoint or end the text travel on to the back end; the
    // front stops accepting when every slot of the middle queue is spoken for
    // by an item already in flight, so the front pipeline itself never stalls.
    //
    // The back end applies the pairwise break rules, keeps the running
    // cluster width and writes results into a small result queue. A
    // transaction that closes a cluster and also ends the text stays at the
    // head of the middle queue until the back end has written both results.

    logic                 mid_push;
    gcs_pkg::class_item_t mid_wdata;
    gcs_pkg::class_item_t mid_rdata;
    logic                 mid_pop;
    logic                 mid_empty;
    logic                 mid_full;

    logic                 res_push;
    gcs_pkg::result_t     res_data;
    logic                 res_full;

    gcs_front #(
        .TRIE_BLOCK_SIZE (TRIE_BLOCK_SIZE),
        .INDEX_DEPTH     (INDEX_DEPTH),
        .BLOCK_COUNT     (BLOCK_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .slot_free (mid_pop),
        .out_valid (mid_push),
        .out_data  (mid_wdata)
    );

    gcs_fifo #(
        .WIDTH ($bits(gcs_pkg::class_item_t)),
        .DEPTH (gcs_pkg::QUEUE_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty),
        .full  (mid_full)
    );

    gcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!mid_empty),
        .head       (mid_rdata),
        .head_pop   (mid_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_data   (res_data)
    );

    // The result queue separates the back end from the consumer, so a
    // finished result can wait here while new transactions keep coming in.
    gcs_fifo #(
        .WIDTH ($bits(gcs_pkg::result_t)),
        .DEPTH (gcs_pkg::RESULT_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .pop   (pop),
        .rdata (result),
        .empty (empty),
        .full  (res_full)
    );

    // The reservation count must keep the middle queue from ever overflowing.
    `GCS_ASSERT_IMP(a_mid_no_overflow, clk, rst_n, mid_push, !mid_full)
    // The back end only takes an item that is there.
    `GCS_ASSERT_IMP(a_mid_pop_valid, clk, rst_n, mid_pop, !mid_empty)
    // The back end only writes a result when the result queue has room.
    `GCS_ASSERT_IMP(a_res_no_overflow, clk, rst_n, res_push, !res_full)
    // The cluster that ends the text is always the final result of its byte.
    `GCS_ASSERT_IMP(a_end_is_last, clk, rst_n, !empty && result.ends_text, result.last_of_run)
    // Reservations only drop when the back end takes an item.
    `GCS_ASSERT_NEXT(a_full_holds, clk, rst_n, full && !mid_pop, full)

endmodule

[tb/sv/grapheme_cluster_segmenter_test.sv]
`timescale 1ns / 1ps

module grapheme_cluster_segmenter_test;

    // Self-checking bench for the grapheme cluster segmenter. Two trie blocks
    // are loaded through table-write transactions, then UTF-8 text is streamed
    // in and every cluster width the block reports is compared against a
    // predictor that runs alongside it. The text only reaches a small set of
    // index entries, so the whole run stays short while every lookup hits a
    // written entry. The run goes through three trie layouts and one long
    // stall on the result side.

    // Opcode that the block must ignore.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int KIND_SPAN   = gcs_pkg::BLOCK_COUNT * gcs_pkg::TRIE_BLOCK_SIZE;
    localparam int WIDTH_CLAMP = 65535;

    // Index entries that the generated text can reach. Entry 0FF holds
    // U+FFFD, which every malformed byte and every value past U+10FFFF uses.
    localparam int HI_COUNT = 6;
    localparam int HI_SET [HI_COUNT] = '{'h000, 'h001, 'h007, 'h0FF, 'h100, 'h10FF};

    // The slowest legal quiet stretch is the result-side hold-off below; the
    // per-transaction waits and the trip through the pipeline are shorter.
    localparam int PRESSURE_CYCLES = 400;
    localparam int IDLE_LIMIT      = 5000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int RANDOM_BYTES    = 100;
    localparam int KIND_REWRITES   = 24;
    localparam int PRINT_CAP       = 40;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              push  = 1'b0;
    logic              full;
    gcs_pkg::in_item_t item  = '0;
    logic              empty;
    logic              pop   = 1'b0;
    gcs_pkg::result_t  result;

    grapheme_cluster_segmenter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of both trie tables plus the decoder and
    // the cluster that is still open.
    // ------------------------------------------------------------------
    logic [7:0]  block_map [gcs_pkg::INDEX_DEPTH];
    logic [3:0]  kind_map  [KIND_SPAN];
    logic [3:0]  prev_kind   = gcs_pkg::KIND_NONE;
    logic        have_prev   = 1'b0;
    int          run_len     = 0;
    logic        run_clamped = 1'b0;
    logic [20:0] cp_acc      = '0;
    int          seq_left    = 0;
    int          seq_len     = 0;

    gcs_pkg::in_item_t pending_items [$];
    gcs_pkg::result_t  expected_clusters [$];

    int   items_queued     = 0;
    int   items_accepted   = 0;
    int   text_bytes       = 0;
    int   table_writes     = 0;
    int   layouts          = 0;
    int   clusters_checked = 0;
    int   mismatch_count   = 0;
    int   idle_cycles      = 0;
    logic pressure_req     = 1'b0;
    logic pressure_taken   = 1'b0;

    // Per-side wait drawing. Now and then a side goes calm for a stretch of
    // transactions with no wait at all, so back-to-back traffic is covered too.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // Kind of a codepoint after the two-level trie walk. Values past the
    // Unicode range are looked up as the replacement character.
    function automatic logic [3:0] lookup_kind(input logic [20:0] cp);
        int code;
        int hi;
        int blk;
        code = (cp > gcs_pkg::MAX_CP) ? int'(gcs_pkg::REPLACEMENT_CP) : int'(cp);
        hi   = code / gcs_pkg::TRIE_BLOCK_SIZE;
        if (hi >= gcs_pkg::INDEX_DEPTH)
            return gcs_pkg::KIND_NONE;
        blk = int'(block_map[hi]);
        if (blk >= gcs_pkg::BLOCK_COUNT)
            return gcs_pkg::KIND_NONE;
        return kind_map[blk * gcs_pkg::TRIE_BLOCK_SIZE + code % gcs_pkg::TRIE_BLOCK_SIZE];
    endfunction

    // Pairwise join decision, written out in rule order: CR LF first, then
    // the control breaks, the Hangul syllable sequences, the extending
    // kinds on the right, Prepend on the left and finally ZWJ before an
    // extended pictographic. Anything else breaks, and None always breaks.
    function automatic logic kinds_join(input logic [3:0] a, input logic [3:0] b);
        if (a == gcs_pkg::KIND_NONE || b == gcs_pkg::KIND_NONE)
            return 1'b0;
        if (a == gcs_pkg::KIND_CR && b == gcs_pkg::KIND_LF)
            return 1'b1;
        if (a == gcs_pkg::KIND_CONTROL || a == gcs_pkg::KIND_CR || a == gcs_pkg::KIND_LF)
            return 1'b0;
        if (b == gcs_pkg::KIND_CONTROL || b == gcs_pkg::KIND_CR || b == gcs_pkg::KIND_LF)
            return 1'b0;
        case (a)
            gcs_pkg::KIND_L:
                if (b == gcs_pkg::KIND_L || b == gcs_pkg::KIND_V ||
                    b == gcs_pkg::KIND_LV || b == gcs_pkg::KIND_LVT)
                    return 1'b1;
            gcs_pkg::KIND_LV, gcs_pkg::KIND_V:
                if (b == gcs_pkg::KIND_V || b == gcs_pkg::KIND_T)
                    return 1'b1;
            gcs_pkg::KIND_LVT, gcs_pkg::KIND_T:
                if (b == gcs_pkg::KIND_T)
                    return 1'b1;
            default:
                ;
        endcase
        if (b == gcs_pkg::KIND_EXTEND || b == gcs_pkg::KIND_ZWJ || b == gcs_pkg::KIND_SPACING)
            return 1'b1;
        if (a == gcs_pkg::KIND_PREPEND)
            return 1'b1;
        return a == gcs_pkg::KIND_ZWJ && b == gcs_pkg::KIND_EXT_PICT;
    endfunction

    function automatic gcs_pkg::result_t finished_cluster(input logic ends);
        gcs_pkg::result_t r;
        r.cluster_bytes   = 16'(run_len);
        r.width_saturated = run_clamped;
        r.ends_text       = ends;
        r.last_of_run     = 1'b0;
        return r;
    endfunction

    task automatic grow_cluster(input int width);
        run_len += width;
        if (run_len > WIDTH_CLAMP)
        begin
            run_len     = WIDTH_CLAMP;
            run_clamped = 1'b1;
        end
    endtask

    // Applies one accepted transaction to the predictor and appends the
    // clusters it finishes (none, one or two) to the expectation queue.
    task automatic predict_clusters(input gcs_pkg::in_item_t it);
        logic             done;
        logic [20:0]      cp;
        logic [7:0]       b;
        logic [3:0]       kind;
        int               width;
        int               produced;
        gcs_pkg::result_t made [2];
        done     = 1'b0;
        cp       = '0;
        width    = 0;
        produced = 0;
        b        = it.data_byte;

        case (it.func)
            gcs_pkg::FUNC_INDEX_WR:
            begin
                if (int'(it.table_address) < gcs_pkg::INDEX_DEPTH)
                    block_map[it.table_address] = it.table_value;
                return;
            end
            gcs_pkg::FUNC_KIND_WR:
            begin
                if (int'(it.table_address) < KIND_SPAN)
                    kind_map[it.table_address] = it.table_value[3:0];
                return;
            end
            gcs_pkg::FUNC_DATA:
                ;
            default:
                return;
        endcase

        if (seq_left > 0)
        begin
            if (b[7:6] == 2'b10)
            begin
                cp_acc = {cp_acc[14:0], b[5:0]};
                seq_len++;
                seq_left--;
                if (seq_left == 0)
                begin
                    done  = 1'b1;
                    cp    = cp_acc;
                    width = seq_len;
                end
            end
            else
            begin
                // A sequence cut short swallows the interrupting byte as well.
                done     = 1'b1;
                cp       = gcs_pkg::REPLACEMENT_CP;
                width    = seq_len + 1;
                seq_left = 0;
            end
        end
        else if (b < 8'h80)
        begin
            done  = 1'b1;
            cp    = {13'd0, b};
            width = 1;
        end
        else if (b < 8'hC0 || b >= 8'hF8)
        begin
            done  = 1'b1;
            cp    = gcs_pkg::REPLACEMENT_CP;
            width = 1;
        end
        else
        begin
            seq_len = 1;
            if (b < 8'hE0)
            begin
                cp_acc   = {16'd0, b[4:0]};
                seq_left = 1;
            end
            else if (b < 8'hF0)
            begin
                cp_acc   = {17'd0, b[3:0]};
                seq_left = 2;
            end
            else
            begin
                cp_acc   = {18'd0, b[2:0]};
                seq_left = 3;
            end
        end

        // Text that ends inside a sequence closes it as one replacement.
        if (!done && it.is_last && seq_left > 0)
        begin
            done     = 1'b1;
            cp       = gcs_pkg::REPLACEMENT_CP;
            width    = seq_len;
            seq_left = 0;
        end

        if (done)
        begin
            kind = lookup_kind(cp);
            if (have_prev && kinds_join(prev_kind, kind))
                grow_cluster(width);
            else
            begin
                if (have_prev)
                begin
                    made[produced] = finished_cluster(1'b0);
                    produced++;
                end
                run_len     = 0;
                run_clamped = 1'b0;
                grow_cluster(width);
            end
            prev_kind = kind;
            have_prev = 1'b1;
            cp_acc    = '0;
            seq_len   = 0;
        end

        if (it.is_last)
        begin
            made[produced] = finished_cluster(1'b1);
            produced++;
            have_prev   = 1'b0;
            prev_kind   = gcs_pkg::KIND_NONE;
            run_len     = 0;
            run_clamped = 1'b0;
            cp_acc      = '0;
            seq_len     = 0;
            seq_left    = 0;
        end

        if (produced > 0)
            made[produced - 1].last_of_run = 1'b1;
        for (int i = 0; i < produced; i++)
            expected_clusters.push_back(made[i]);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the pending transactions one by one, waiting a drawn
    // number of cycles after each accepted one. The prediction is made at
    // the edge that accepts the transaction.
    // ------------------------------------------------------------------
    int send_wait = 0;
    int send_calm = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push      <= 1'b0;
            item      <= '0;
            send_wait = 0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_clusters(item);
                items_accepted++;
            end
            // A transaction still blocked by full stays on the port untouched.
            if (!push || !full)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    push <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    item      <= pending_items.pop_front();
                    push      <= 1'b1;
                    send_wait = draw_wait(send_calm);
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes results with random stalls, checks each one against the
    // oldest expectation, and once per run holds off for a long stretch so
    // the block backs up and raises full. Values are printed as
    // bytes/saturated/ends_text/last_of_run.
    // ------------------------------------------------------------------
    int               recv_wait = 0;
    int               recv_calm = 0;
    int               hold_left = 0;
    gcs_pkg::result_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop       <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_clusters.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= PRINT_CAP)
                        $display("%0t: unexpected cluster, expected none, got %0d/%0b/%0b/%0b",
                                 $time, result.cluster_bytes, result.width_saturated,
                                 result.ends_text, result.last_of_run);
                end
                else
                begin
                    want = expected_clusters.pop_front();
                    clusters_checked++;
                    if (result.cluster_bytes !== want.cluster_bytes ||
                        result.width_saturated !== want.width_saturated ||
                        result.ends_text !== want.ends_text ||
                        result.last_of_run !== want.last_of_run)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= PRINT_CAP)
                            $display("%0t: mismatch, expected %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
                                     $time, want.cluster_bytes, want.width_saturated,
                                     want.ends_text, want.last_of_run,
                                     result.cluster_bytes, result.width_saturated,
                                     result.ends_text, result.last_of_run);
                    end
                end
                recv_wait = draw_wait(recv_calm);
            end

            if (pressure_req && !pressure_taken)
            begin
                pressure_taken = 1'b1;
                hold_left      = PRESSURE_CYCLES;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog: a long stretch with no transaction on either side means the
    // block has hung or dropped results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic gcs_pkg::in_item_t make_item(input logic [1:0] func,
                                                    input logic [7:0] b,
                                                    input logic last,
                                                    input logic [15:0] addr,
                                                    input logic [7:0] val);
        gcs_pkg::in_item_t it;
        it.func          = func;
        it.data_byte     = b;
        it.is_last       = last;
        it.table_address = addr;
        it.table_value   = val;
        return it;
    endfunction

    function automatic gcs_pkg::in_item_t text_item(input logic [7:0] b, input logic last);
        return make_item(gcs_pkg::FUNC_DATA, b, last, 16'($urandom), 8'($urandom));
    endfunction

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    // Half of the kinds come from the ones that tend to join, so clusters
    // longer than one codepoint show up often.
    function automatic logic [3:0] draw_kind();
        if ($urandom_range(0, 1) == 1)
            return 4'($urandom_range(gcs_pkg::KIND_EXTEND, gcs_pkg::KIND_EXT_PICT));
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic queue_item(input gcs_pkg::in_item_t it);
        pending_items.push_back(it);
        items_queued++;
        if (it.func == gcs_pkg::FUNC_DATA)
            text_bytes++;
        else if (it.func == gcs_pkg::FUNC_INDEX_WR || it.func == gcs_pkg::FUNC_KIND_WR)
            table_writes++;
    endtask

    // One string of text; its final byte carries the end-of-text mark.
    task automatic send_text(input logic [7:0] bytes [$]);
        foreach (bytes[i])
            queue_item(text_item(bytes[i], i == bytes.size() - 1));
    endtask

    // Waits until every queued transaction has been taken and every expected
    // cluster has come back, then lets the pipeline drain of bytes that made
    // no result.
    task automatic settle();
        while (items_accepted != items_queued || expected_clusters.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Fills one block of the kind table. Its first 16 entries hold kinds
    // 0..15 in order, so the text bytes 00..0F have a known kind whichever
    // block the first index entry picks.
    task automatic fill_block(input logic [7:0] blk);
        logic [3:0] kind;
        for (int off = 0; off < gcs_pkg::TRIE_BLOCK_SIZE; off++)
        begin
            kind = (off < 16) ? 4'(off) : draw_kind();
            queue_item(make_item(gcs_pkg::FUNC_KIND_WR, 8'($urandom), 1'($urandom),
                                 16'(int'(blk) * gcs_pkg::TRIE_BLOCK_SIZE + off),
                                 {4'($urandom), kind}));
        end
    endtask

    // Points every reachable index entry at one of the given blocks.
    task automatic map_index(input logic [7:0] blocks [$]);
        for (int k = 0; k < HI_COUNT; k++)
            queue_item(make_item(gcs_pkg::FUNC_INDEX_WR, 8'($urandom), 1'($urandom),
                                 16'(HI_SET[k]),
                                 blocks[$urandom_range(0, blocks.size() - 1)]));
    endtask

    // Random strings of 1..10 codepoints. Well-formed codepoints come from
    // the reachable index entries, in every legal length (overlong forms
    // included), plus 4-byte values past the Unicode range. The rest are
    // stray bytes, cut sequences and transactions the block must ignore.
    // A continuation byte never directly follows a cut sequence, since it
    // could complete it into an unreachable codepoint. A cut sequence at the
    // end of a string gives the truncated-end case.
    task automatic queue_random_text(input int budget);
        gcs_pkg::in_item_t run [$];
        logic [7:0]        lead;
        logic [20:0]       cp;
        logic              open_cut;
        int                data_left;
        int                pick;
        int                n_cp;
        int                needed;
        int                conts;
        int                len;
        int                last_data;
        int                data_count;
        data_left = budget;
        while (data_left > 0)
        begin
            run.delete();
            open_cut = 1'b0;
            n_cp     = $urandom_range(1, 10);
            for (int c = 0; c < n_cp; c++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40 || (pick >= 85 && pick < 90 && open_cut))
                begin
                    if ($urandom_range(0, 1) == 1)
                        run.push_back(text_item(8'($urandom_range(0, 15)), 1'b0));
                    else
                        run.push_back(text_item(8'($urandom_range(0, 127)), 1'b0));
                    open_cut = 1'b0;
                end
                else if (pick < 85)
                begin
                    if (pick < 80)
                    begin
                        cp  = 21'(HI_SET[$urandom_range(0, HI_COUNT - 1)] *
                                  gcs_pkg::TRIE_BLOCK_SIZE +
                                  $urandom_range(0, gcs_pkg::TRIE_BLOCK_SIZE - 1));
                        len = (cp < 21'h800) ? $urandom_range(2, 4) :
                              (cp < 21'h10000) ? $urandom_range(3, 4) : 4;
                    end
                    else
                    begin
                        cp  = 21'($urandom_range('h110000, 'h1FFFFF));
                        len = 4;
                    end
                    case (len)
                        2:
                        begin
                            run.push_back(text_item({3'b110, cp[10:6]}, 1'b0));
                            run.push_back(text_item({2'b10, cp[5:0]}, 1'b0));
                        end
                        3:
                        begin
                            run.push_back(text_item({4'b1110, cp[15:12]}, 1'b0));
                            run.push_back(text_item({2'b10, cp[11:6]}, 1'b0));
                            run.push_back(text_item({2'b10, cp[5:0]}, 1'b0));
                        end
                        default:
                        begin
                            run.push_back(text_item({5'b11110, cp[20:18]}, 1'b0));
                            run.push_back(text_item({2'b10, cp[17:12]}, 1'b0));
                            run.push_back(text_item({2'b10, cp[11:6]}, 1'b0));
                            run.push_back(text_item({2'b10, cp[5:0]}, 1'b0));
                        end
                    endcase
                    open_cut = 1'b0;
                end
                else if (pick < 90)
                    run.push_back(text_item(cont_byte(), 1'b0));
                else if (pick < 94)
                begin
                    run.push_back(text_item(8'($urandom_range(8'hF8, 8'hFF)), 1'b0));
                    open_cut = 1'b0;
                end
                else if (pick < 98)
                begin
                    lead   = 8'($urandom_range(8'hC0, 8'hF7));
                    needed = (lead < 8'hE0) ? 1 : (lead < 8'hF0) ? 2 : 3;
                    conts  = $urandom_range(0, needed - 1);
                    run.push_back(text_item(lead, 1'b0));
                    for (int k = 0; k < conts; k++)
                        run.push_back(text_item(cont_byte(), 1'b0));
                    open_cut = 1'b1;
                end
                else if ($urandom_range(0, 1) == 1)
                    run.push_back(make_item(FUNC_UNUSED, 8'($urandom), 1'($urandom),
                                            16'($urandom), 8'($urandom)));
                else
                    run.push_back(make_item(gcs_pkg::FUNC_INDEX_WR, 8'($urandom),
                                            1'($urandom),
                                            16'($urandom_range(gcs_pkg::INDEX_DEPTH, 65535)),
                                            8'($urandom)));
            end

            last_data  = -1;
            data_count = 0;
            foreach (run[i])
                if (run[i].func == gcs_pkg::FUNC_DATA)
                begin
                    last_data = i;
                    data_count++;
                end
            if (last_data < 0)
            begin
                run.push_back(text_item(8'($urandom_range(0, 127)), 1'b0));
                last_data  = run.size() - 1;
                data_count = 1;
            end
            run[last_data].is_last = 1'b1;
            foreach (run[i])
                queue_item(run[i]);
            data_left -= data_count;
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] text [$];
        logic [7:0] blocks [$];

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // First layout: two blocks whose numbers toggle every bit.
        blocks = {8'h5A, 8'hA5};
        foreach (blocks[i])
            fill_block(blocks[i]);
        map_index(blocks);
        layouts++;
        settle();

        // Directed text. Bytes 00..0F carry kinds 0..15 in order.
        text = {8'h01, 8'h02};                      // CR LF stays together
        send_text(text);
        text = {8'h03, 8'h04};                      // Control breaks even before Extend
        send_text(text);
        text = {8'h08, 8'h09, 8'h0A, 8'h0A};        // L V T T
        send_text(text);
        text = {8'h08, 8'h0C, 8'h08, 8'h0B, 8'h0A}; // L LVT | L LV T
        send_text(text);
        text = {8'h0C, 8'h0A, 8'h09, 8'h08};        // LVT T, then T before V and V before L break
        send_text(text);
        text = {8'h07, 8'h0D, 8'h06};               // Prepend, pictographic, SpacingMark
        send_text(text);
        text = {8'h04, 8'h05, 8'h0D};               // Extend ZWJ pictographic
        send_text(text);
        text = {8'h00, 8'h04, 8'h0E, 8'h0F, 8'h06}; // None breaks; unassigned kinds
        send_text(text);
        // Two-, three- and four-byte forms, up to U+10FFFF.
        text = {8'hC3, 8'hA9, 8'hE0, 8'h84, 8'h80, 8'hEF, 8'hBF, 8'hBD,
                8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_text(text);
        text = {8'h80, 8'hFF, 8'hF8, 8'h7F};        // stray bytes
        send_text(text);
        text = {8'hE2, 8'h41, 8'hF7, 8'hBF, 8'hBF, 8'hBF}; // cut sequence, past U+10FFFF
        send_text(text);
        text = {8'h41, 8'hF0, 8'h9F};               // text ends inside a sequence
        send_text(text);
        queue_item(make_item(FUNC_UNUSED, 8'hFF, 1'b1, 16'hFFFF, 8'hFF));
        queue_item(make_item(gcs_pkg::FUNC_INDEX_WR, 8'h00, 1'b1, 16'hFFFF, 8'h00));
        text = {8'hE2};                             // lone lead byte as the whole text
        send_text(text);
        settle();

        // Random text, with the long result-side hold-off near its start.
        pressure_req = 1'b1;
        queue_random_text(RANDOM_BYTES);
        settle();

        // Second layout: the same blocks behind a new index, some kinds rewritten.
        map_index(blocks);
        repeat (KIND_REWRITES)
            queue_item(make_item(gcs_pkg::FUNC_KIND_WR, 8'($urandom), 1'($urandom),
                                 16'(int'(blocks[$urandom_range(0, blocks.size() - 1)]) *
                                     gcs_pkg::TRIE_BLOCK_SIZE +
                                     $urandom_range(0, gcs_pkg::TRIE_BLOCK_SIZE - 1)),
                                 {4'($urandom), draw_kind()}));
        layouts++;
        settle();
        queue_random_text(RANDOM_BYTES);
        settle();

        // Third layout: every reachable index entry points at one block.
        blocks = {8'h5A};
        map_index(blocks);
        layouts++;
        settle();
        queue_random_text(RANDOM_BYTES);
        settle();

        mismatch_count += expected_clusters.size();
        $display("Streamed %0d text bytes and %0d table writes over %0d trie layouts,",
                 text_bytes, table_writes, layouts);
        $display("checked %0d clusters, with one long stall on the result side.",
                 clusters_checked);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
